@@ src/clsr_pkg.sv @@
`default_nettype none

package clsr_pkg;

    localparam logic [30:0] MOD_A     = 31'd2147483563;
    localparam logic [30:0] MOD_B     = 31'd2147483399;
    localparam logic [15:0] MUL_A     = 16'd40014;
    localparam logic [15:0] MUL_B     = 16'd40692;
    // 2^31 minus each modulus
    localparam logic [7:0]  FOLD_A    = 8'd85;
    localparam logic [7:0]  FOLD_B    = 8'd249;
    localparam logic [30:0] WRAP_TOP  = 31'd2147483562;
    localparam logic [30:0] SEED_B    = 31'd123456789;
    localparam logic [7:0]  FRAC_MUL  = 8'd170;
    localparam logic [31:0] FRAC_CEIL = 32'd4294966780;

    typedef struct packed {
        logic load;
        logic mul;
        logic ri_red;
        logic dr_red;
        logic rd;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic need_reinit;
        logic cnt_zero;
        logic emit_ok;
    } t_sts;

endpackage

`default_nettype wire

@@ src/clsr_in_if.sv @@
`default_nettype none

interface clsr_in_if;
    logic               valid;
    logic               ready;
    logic               mode;
    logic signed [31:0] seed;

    modport source (output valid, output mode, output seed, input ready);
    modport sink   (input valid, input mode, input seed, output ready);
endinterface

`default_nettype wire

@@ src/clsr_out_if.sv @@
`default_nettype none

interface clsr_out_if;
    logic        valid;
    logic        ready;
    logic [30:0] raw_value;
    logic [31:0] fraction_q32;

    modport source (output valid, output raw_value, output fraction_q32, input ready);
    modport sink   (input valid, input raw_value, input fraction_q32, output ready);
endinterface

`default_nettype wire

@@ src/clsr_ctrl.sv @@
`default_nettype none

module clsr_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire clsr_pkg::t_sts i_sts,
    output clsr_pkg::t_cmd     o_cmd
);
    import clsr_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_RI_MUL = 3'd1;
    localparam logic [2:0] S_RI_RED = 3'd2;
    localparam logic [2:0] S_D_MUL  = 3'd3;
    localparam logic [2:0] S_D_RED  = 3'd4;
    localparam logic [2:0] S_D_RD   = 3'd5;
    localparam logic [2:0] S_D_Y    = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.need_reinit ? S_RI_MUL : S_D_RED;
                end
            end
            S_RI_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_RI_RED;
            end
            S_RI_RED: begin
                o_cmd.ri_red = 1'b1;
                n_state      = i_sts.cnt_zero ? S_D_MUL : S_RI_MUL;
            end
            S_D_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_D_RED;
            end
            S_D_RED: begin
                o_cmd.dr_red = 1'b1;
                n_state      = S_D_RD;
            end
            S_D_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_D_Y;
            end
            S_D_Y: begin
                if (i_sts.emit_ok) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

@@ src/clsr_dpath.sv @@
`default_nettype none

module clsr_dpath #(
    parameter int TABLE_DEPTH = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire clsr_pkg::t_cmd     i_cmd,
    output clsr_pkg::t_sts          o_sts,
    input  wire logic               i_mode,
    input  wire logic signed [31:0] i_seed,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [30:0]             o_raw_value,
    output logic [31:0]             o_fraction_q32
);
    import clsr_pkg::*;

    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 8);
    localparam longint unsigned SLOT_DIV = 64'd1 + 64'(WRAP_TOP) / TABLE_DEPTH;
    localparam longint unsigned RECIP    = (64'd1 << 31) / SLOT_DIV;
    localparam int RCP_W = $clog2(RECIP + 1);
    localparam int QP_W  = 31 + RCP_W;
    localparam int QD_W  = 32 + RCP_W;

    function automatic logic [30:0] mod_fold(input logic [47:0] prod,
                                             input logic [7:0]  fold,
                                             input logic [30:0] modulus);
        logic [31:0] p1;
        p1 = 32'(prod[30:0]) + 32'(prod[47:31]) * 32'(fold);
        if (p1 >= 32'(modulus)) begin
            p1 = p1 - 32'(modulus);
        end
        return p1[30:0];
    endfunction

    logic [31:0]      r_first;
    logic [31:0]      r_second;
    logic [30:0]      r_last;
    logic [47:0]      r_prod_a;
    logic [47:0]      r_prod_b;
    logic [RCP_W-1:0] r_q0;
    logic [QD_W-1:0]  r_qd;
    logic [CNT_W-1:0] r_cnt;
    logic [30:0]      r_mem [TABLE_DEPTH];
    logic [30:0]      r_rd;
    logic             r_f1_v;
    logic [30:0]      r_f1_raw;
    logic [38:0]      r_f1_t;
    logic             r_out_v;
    logic [30:0]      r_out_raw;
    logic [31:0]      r_out_frac;

    logic [31:0]      in_val;
    logic [31:0]      mag;
    logic [31:0]      op_a;
    logic [30:0]      red_a;
    logic [30:0]      red_b;
    logic [QP_W-1:0]  q0_prod;
    logic [RCP_W:0]   q0_inc;
    logic             slot_up;
    logic [RCP_W:0]   slot_raw;
    logic [RCP_W:0]   slot_clip;
    logic [IDX_W-1:0] slot;
    logic             mem_we;
    logic [IDX_W-1:0] mem_wa;
    logic [30:0]      mem_wd;
    logic [32:0]      diff;
    logic [32:0]      y_wide;
    logic [30:0]      y;
    logic             f2_go;
    logic [7:0]       fq0;
    logic [31:0]      fr0;
    logic [7:0]       fq;
    logic [32:0]      fsum;
    logic [31:0]      frac;

    assign in_val = i_mode ? i_seed : r_first;
    assign mag    = (in_val == '0) ? 32'd1 : (~in_val + 32'd1);
    assign op_a   = i_cmd.load ? in_val : r_first;
    assign red_a  = mod_fold(r_prod_a, FOLD_A, MOD_A);
    assign red_b  = mod_fold(r_prod_b, FOLD_B, MOD_B);

    // table slot: reciprocal estimate then one correction
    assign q0_prod   = QP_W'(r_last) * QP_W'(RECIP);
    assign q0_inc    = {1'b0, r_q0} + (RCP_W + 1)'(1);
    assign slot_up   = (QD_W'(r_last) >= r_qd);
    assign slot_raw  = {1'b0, r_q0} + (RCP_W + 1)'(slot_up);
    assign slot_clip = (slot_raw > (RCP_W + 1)'(TABLE_DEPTH - 1)) ?
                       (RCP_W + 1)'(TABLE_DEPTH - 1) : slot_raw;
    assign slot      = slot_clip[IDX_W-1:0];

    assign mem_we = (i_cmd.ri_red && (r_cnt < CNT_W'(TABLE_DEPTH))) || i_cmd.rd;
    assign mem_wa = i_cmd.rd ? slot : r_cnt[IDX_W-1:0];
    assign mem_wd = i_cmd.rd ? r_first[30:0] : red_a;

    assign diff   = {2'b00, r_rd} - {1'b0, r_second};
    assign y_wide = (diff[32] || (diff == '0)) ? (diff + 33'(WRAP_TOP)) : diff;
    assign y      = y_wide[30:0];

    // fraction: floor(y * 2^32 / m) = 2y + floor(170y / m)
    assign f2_go = r_f1_v && (!r_out_v || i_out_ready);
    assign fq0   = r_f1_t[38:31];
    assign fr0   = 32'(r_f1_t[30:0]) + 32'(fq0) * 32'(FOLD_A);
    assign fq    = fq0 + 8'(fr0 >= 32'(MOD_A));
    assign fsum  = {1'b0, r_f1_raw, 1'b0} + 33'(fq);
    assign frac  = (fsum > 33'(FRAC_CEIL)) ? FRAC_CEIL : fsum[31:0];

    assign o_sts.need_reinit = in_val[31] || (in_val == '0);
    assign o_sts.cnt_zero    = (r_cnt == '0);
    assign o_sts.emit_ok     = !r_f1_v || f2_go;

    assign o_out_valid    = r_out_v;
    assign o_raw_value    = r_out_raw;
    assign o_fraction_q32 = r_out_frac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first  <= '0;
            r_second <= 32'(SEED_B);
            r_last   <= '0;
        end else begin
            if (i_cmd.load && o_sts.need_reinit) begin
                r_first  <= mag;
                r_second <= mag;
            end
            if (i_cmd.ri_red) begin
                r_first <= {1'b0, red_a};
                if (o_sts.cnt_zero) begin
                    r_last <= red_a;
                end
            end
            if (i_cmd.dr_red) begin
                r_first  <= {1'b0, red_a};
                r_second <= {1'b0, red_b};
            end
            if (i_cmd.emit) begin
                r_last <= y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load || i_cmd.mul) begin
            r_prod_a <= 48'(MUL_A) * 48'(op_a);
            r_prod_b <= 48'(MUL_B) * 48'(r_second);
            r_q0     <= q0_prod[QP_W-1:31];
        end
        if (i_cmd.load) begin
            r_cnt <= CNT_W'(TABLE_DEPTH + 7);
        end else if (i_cmd.ri_red && !o_sts.cnt_zero) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
        if (i_cmd.dr_red) begin
            r_qd <= QD_W'(q0_inc) * QD_W'(SLOT_DIV);
        end
        if (i_cmd.emit) begin
            r_f1_raw <= y;
            r_f1_t   <= 39'(y) * 39'(FRAC_MUL);
        end
        if (f2_go) begin
            r_out_raw  <= r_f1_raw;
            r_out_frac <= frac;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (i_cmd.rd) begin
            r_rd <= r_mem[slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (i_cmd.emit) begin
                r_f1_v <= 1'b1;
            end else if (f2_go) begin
                r_f1_v <= 1'b0;
            end
            if (f2_go) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

@@ src/combined_lcg_shuffle_random.sv @@
`default_nettype none

// Combined random generator: two multiplicative congruential generators
// (multipliers 40014 and 40692) mixed through a TABLE_DEPTH-entry shuffle
// table. Each input item either draws the next number or loads a seed and
// then draws; every item gives one result item with the raw integer and
// its Q0.32 fraction of 2147483563. A normal draw passes through accept
// with both multiplies, reduction, table access and combine, which waits
// while the output pipeline is full; the fraction is finished in a
// two-stage output pipeline, so the next item can be accepted while a
// result is still being finished. A draw that finds the first generator
// zero or negative (always the first draw after reset unless it loads a
// positive seed) first reseeds and refills the table, stepping the first
// generator TABLE_DEPTH+8 times through its multiply and reduce loop.
module combined_lcg_shuffle_random #(
    parameter int TABLE_DEPTH = 32
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    clsr_in_if.sink     i_item,
    clsr_out_if.source  o_result
);
    import clsr_pkg::*;

    t_cmd cmd;
    t_sts sts;

    clsr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (i_item.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    clsr_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_mode         (i_item.mode),
        .i_seed         (i_item.seed),
        .o_out_valid    (o_result.valid),
        .i_out_ready    (o_result.ready),
        .o_raw_value    (o_result.raw_value),
        .o_fraction_q32 (o_result.fraction_q32)
    );

endmodule

`default_nettype wire

@@ tb/clsr_checker.sv @@
module clsr_checker #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    clsr_in_if   item_if,
    clsr_out_if  result_if,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import clsr_pkg::*;

    localparam longint MOD_A_W  = MOD_A;
    localparam longint MOD_B_W  = MOD_B;
    localparam longint MUL_A_W  = MUL_A;
    localparam longint MUL_B_W  = MUL_B;
    localparam longint QUO_A    = 53668;
    localparam longint QUO_B    = 52774;
    localparam longint REM_A    = 12211;
    localparam longint REM_B    = 3791;
    localparam longint WRAP_W   = WRAP_TOP;
    localparam longint CEIL_W   = FRAC_CEIL;
    localparam longint SLOT_DIV = 1 + WRAP_W / TABLE_DEPTH;
    localparam int PRINT_LIMIT  = 50;

    typedef struct packed {
        logic [30:0] raw;
        logic [31:0] frac;
    } t_draw;

    longint lcg_a = 0;
    longint lcg_b = SEED_B;
    longint prev_raw = 0;
    longint slots [TABLE_DEPTH];
    t_draw  expected_draws [$];
    int     mismatches = 0;

    assign o_fail_count = mismatches;

    function automatic longint schrage_step(longint x, longint mul, longint quo,
                                            longint rem, longint modulus);
        longint k;
        longint v;
        k = x / quo;
        v = mul * (x - k * quo) - k * rem;
        if (v < 0) begin
            v += modulus;
        end
        return v;
    endfunction

    task automatic report_mismatch(input string what, input longint got,
                                   input longint want);
        if (mismatches < PRINT_LIMIT) begin
            $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        end
        mismatches++;
    endtask

    // reseed generator b from a and refill the table from the top slot down
    task automatic refill_table();
        longint x;
        x = (lcg_a == 0) ? 1 : -lcg_a;
        lcg_b = x;
        for (int i = TABLE_DEPTH + 7; i >= 0; i--) begin
            x = schrage_step(x, MUL_A_W, QUO_A, REM_A, MOD_A_W);
            if (i < TABLE_DEPTH) begin
                slots[i] = x;
            end
        end
        lcg_a = x;
        prev_raw = slots[0];
    endtask

    task automatic predict_draw(input logic mode, input logic signed [31:0] seed);
        longint slot;
        longint y;
        longint frac;
        t_draw  d;
        if (mode) begin
            lcg_a = longint'(seed);
        end
        if (lcg_a <= 0) begin
            refill_table();
        end
        lcg_a = schrage_step(lcg_a, MUL_A_W, QUO_A, REM_A, MOD_A_W);
        lcg_b = schrage_step(lcg_b, MUL_B_W, QUO_B, REM_B, MOD_B_W);
        slot = prev_raw / SLOT_DIV;
        if (slot < 0) begin
            slot = 0;
        end
        if (slot > TABLE_DEPTH - 1) begin
            slot = TABLE_DEPTH - 1;
        end
        y = slots[int'(slot)] - lcg_b;
        slots[int'(slot)] = lcg_a;
        if (y < 1) begin
            y += WRAP_W;
        end
        prev_raw = y;
        frac = (y <<< 32) / MOD_A_W;
        if (frac > CEIL_W) begin
            frac = CEIL_W;
        end
        d.raw = y[30:0];
        d.frac = frac[31:0];
        expected_draws.push_back(d);
    endtask

    always @(posedge i_clk) begin
        t_draw want;
        if (!i_rst_n) begin
            lcg_a = 0;
            lcg_b = SEED_B;
            prev_raw = 0;
            foreach (slots[i]) begin
                slots[i] = 0;
            end
            expected_draws.delete();
        end else begin
            if (item_if.valid && item_if.ready) begin
                predict_draw(item_if.mode, item_if.seed);
            end
            if (result_if.valid && result_if.ready) begin
                if (expected_draws.size() == 0) begin
                    report_mismatch("unexpected result item", result_if.raw_value, 0);
                end else begin
                    want = expected_draws.pop_front();
                    if (result_if.raw_value !== want.raw) begin
                        report_mismatch("raw_value", result_if.raw_value, want.raw);
                    end
                    if (result_if.fraction_q32 !== want.frac) begin
                        report_mismatch("fraction_q32", result_if.fraction_q32, want.frac);
                    end
                end
            end
        end
        o_pending <= expected_draws.size();
    end

endmodule

@@ tb/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import clsr_pkg::*;

    localparam int TABLE_DEPTH = 32;
    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_CYCLES = 200;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    bit   quiet = 1'b0;
    int   hold_len = 0;
    int   idle_cycles = 0;
    int   fail_count;
    int   pending;

    clsr_in_if  item_if ();
    clsr_out_if result_if ();

    combined_lcg_shuffle_random #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_item  (item_if),
        .o_result(result_if)
    );

    clsr_checker #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .item_if     (item_if),
        .result_if   (result_if),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int gap_len();
        return quiet ? 0 : int'($urandom_range(0, 5));
    endfunction

    function automatic logic signed [31:0] pick_seed();
        logic signed [31:0] s;
        case ($urandom_range(0, 7))
            0: s = int'($urandom_range(1, 1000));
            1: s = -int'($urandom_range(0, 1000));
            2: s = int'(MOD_A) - 4 + int'($urandom_range(0, 8));
            3: s = int'(MOD_B) - 4 + int'($urandom_range(0, 8));
            4: s = $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
            default: s = $urandom;
        endcase
        return s;
    endfunction

    task automatic send_item(input logic m, input logic signed [31:0] s);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_if.valid <= 1'b1;
        item_if.mode <= m;
        item_if.seed <= s;
        @(posedge clk);
        while (!item_if.ready) @(posedge clk);
    endtask

    task automatic random_items(input int n);
        logic m;
        repeat (n) begin
            m = ($urandom_range(0, 9) == 0);
            send_item(m, m ? pick_seed() : $urandom);
        end
    endtask

    task automatic drain();
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // result side
    initial begin
        int pause_len;
        result_if.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            pause_len = gap_len() + hold_len;
            hold_len = 0;
            if (pause_len > 0) begin
                result_if.ready <= 1'b0;
                repeat (pause_len) @(posedge clk);
            end
            result_if.ready <= 1'b1;
            @(posedge clk);
            while (!result_if.valid) @(posedge clk);
        end
    end

    always @(posedge clk) begin
        if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        item_if.valid <= 1'b0;
        item_if.mode <= 1'b0;
        item_if.seed <= '0;
        rst_n <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        quiet = 1'b1;
        // first draw after reset refills from a zero state
        send_item(1'b0, 32'sh0);
        send_item(1'b0, 32'shffff_ffff);
        send_item(1'b1, 32'sd1);
        send_item(1'b0, 32'sh0);
        send_item(1'b1, 32'sh7fff_ffff);
        send_item(1'b0, 32'sh0);
        // most negative seed, minus one and zero all force a refill
        send_item(1'b1, 32'sh8000_0000);
        send_item(1'b1, -32'sd1);
        send_item(1'b1, 32'sh0);
        // seed equal to the first modulus steps to zero, next draw refills
        send_item(1'b1, int'(MOD_A));
        send_item(1'b0, 32'sh0);
        send_item(1'b1, int'(MOD_A) - 1);
        send_item(1'b1, int'(MOD_A) + 1);
        send_item(1'b1, int'(MOD_B));
        send_item(1'b1, int'(MOD_B) + 1);
        send_item(1'b1, 32'sd53668);
        send_item(1'b1, 32'sd52774);
        send_item(1'b0, 32'sh5555_5555);
        send_item(1'b0, 32'shaaaa_aaaa);
        quiet = 1'b0;

        random_items(400);
        // receiver holds off while items keep coming
        hold_len = HOLD_CYCLES;
        random_items(40);
        item_if.valid <= 1'b0;
        drain();
        quiet = 1'b1;
        random_items(150);
        quiet = 1'b0;
        random_items(740);
        item_if.valid <= 1'b0;

        drain();
        repeat (20) @(posedge clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
